// ----- hdl/tao_pkg.sv -----
// tao_pkg: shared types, widths and the arctangent table for the tilt angle block
// no dependencies; used by every module under hdl
package tao_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int NUM_CELLS     = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int IDX_W         = $clog2(TABLE_LEN);

  localparam int IN_W       = 16;
  localparam int GUARD_BITS = 8;
  localparam int FRAC_BITS  = 16;
  localparam int VEC_W      = IN_W + GUARD_BITS + 3;
  localparam int ANG_W      = FRAC_BITS + 11;
  localparam int DEG_W      = 9;
  localparam int MAG_W      = 8;

  localparam logic signed [ANG_W-1:0] DEG_180  = ANG_W'(180 * (1 << FRAC_BITS));
  localparam logic signed [ANG_W-1:0] DEG_N180 = -DEG_180;
  localparam logic [ANG_W-1:0]        HALF_DEG = ANG_W'(1 << (FRAC_BITS - 1));

  localparam logic signed [DEG_W-1:0] LIM_P45  = DEG_W'(45);
  localparam logic signed [DEG_W-1:0] LIM_P135 = DEG_W'(135);
  localparam logic signed [DEG_W-1:0] LIM_N45  = -DEG_W'(45);
  localparam logic signed [DEG_W-1:0] LIM_N135 = -DEG_W'(135);

  typedef enum logic [1:0] {
    ORIENT_TOP    = 2'd0,
    ORIENT_RIGHT  = 2'd1,
    ORIENT_LEFT   = 2'd2,
    ORIENT_BOTTOM = 2'd3
  } orient_t;

  typedef struct packed {
    logic                    zero;
    logic signed [VEC_W-1:0] n;
    logic signed [VEC_W-1:0] d;
    logic signed [ANG_W-1:0] a;
  } tao_data_t;

  typedef struct packed {
    logic signed [DEG_W-1:0] angle;
    logic [MAG_W-1:0]        mag;
    logic                    neg;
    orient_t                 orient;
  } tao_result_t;

  // atan(2^-i) in degrees, 16 fractional bits, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_q16(input logic [IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = ANG_W'(2949120);
      5'd1:    v = ANG_W'(1740967);
      5'd2:    v = ANG_W'(919879);
      5'd3:    v = ANG_W'(466945);
      5'd4:    v = ANG_W'(234379);
      5'd5:    v = ANG_W'(117304);
      5'd6:    v = ANG_W'(58666);
      5'd7:    v = ANG_W'(29335);
      5'd8:    v = ANG_W'(14668);
      5'd9:    v = ANG_W'(7334);
      5'd10:   v = ANG_W'(3667);
      5'd11:   v = ANG_W'(1833);
      5'd12:   v = ANG_W'(917);
      5'd13:   v = ANG_W'(458);
      5'd14:   v = ANG_W'(229);
      5'd15:   v = ANG_W'(115);
      5'd16:   v = ANG_W'(57);
      5'd17:   v = ANG_W'(29);
      5'd18:   v = ANG_W'(14);
      5'd19:   v = ANG_W'(7);
      5'd20:   v = ANG_W'(4);
      5'd21:   v = ANG_W'(2);
      5'd22:   v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/tao_prep.sv -----
// tao_prep: input register stage, scales the sample and folds the lower half plane
// depends on tao_pkg
module tao_prep (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic signed [15:0]           accel_x,
  input  logic signed [15:0]           accel_y,
  output logic                         vld_r,
  output tao_pkg::tao_data_t           data_r
);

  tao_pkg::tao_data_t data_nxt;
  logic signed [tao_pkg::VEC_W-1:0] xs;
  logic signed [tao_pkg::VEC_W-1:0] ys;

  always_comb begin
    xs = tao_pkg::VEC_W'(accel_x) <<< tao_pkg::GUARD_BITS;
    ys = tao_pkg::VEC_W'(accel_y) <<< tao_pkg::GUARD_BITS;
    data_nxt.zero = (accel_x == '0) && (accel_y == '0);
    if (accel_y < 0) begin
      data_nxt.n = -xs;
      data_nxt.d = -ys;
      data_nxt.a = (accel_x >= 0) ? tao_pkg::DEG_180 : tao_pkg::DEG_N180;
    end else begin
      data_nxt.n = xs;
      data_nxt.d = ys;
      data_nxt.a = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- hdl/tao_cell.sv -----
// tao_cell: one vectoring micro-rotation with its pipeline register
// depends on tao_pkg (data struct and arctangent table)
module tao_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic [tao_pkg::IDX_W-1:0]    idx,
  input  logic                         vld_i,
  input  tao_pkg::tao_data_t           data_i,
  output logic                         vld_r,
  output tao_pkg::tao_data_t           data_r
);

  tao_pkg::tao_data_t data_nxt;
  logic signed [tao_pkg::VEC_W-1:0] ns;
  logic signed [tao_pkg::VEC_W-1:0] ds;
  logic signed [tao_pkg::ANG_W-1:0] step;

  always_comb begin
    ns   = data_i.n >>> idx;
    ds   = data_i.d >>> idx;
    step = tao_pkg::atan_q16(idx);
    data_nxt.zero = data_i.zero;
    if (data_i.n > 0) begin
      data_nxt.d = data_i.d + ns;
      data_nxt.n = data_i.n - ds;
      data_nxt.a = data_i.a + step;
    end else begin
      data_nxt.d = data_i.d - ns;
      data_nxt.n = data_i.n + ds;
      data_nxt.a = data_i.a - step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- hdl/tao_post.sv -----
// tao_post: saturates the angle, rounds to degrees and picks the orientation
// depends on tao_pkg
module tao_post (
  input  tao_pkg::tao_data_t   data_i,
  output tao_pkg::tao_result_t res
);

  logic signed [tao_pkg::ANG_W-1:0] a_sat;
  logic [tao_pkg::ANG_W-1:0]        mag;
  logic [tao_pkg::ANG_W-1:0]        mag_rnd;
  logic [tao_pkg::MAG_W-1:0]        r_mag;
  logic signed [tao_pkg::DEG_W-1:0] r;

  always_comb begin
    if (data_i.zero) begin
      a_sat = '0;
    end else if (data_i.a > tao_pkg::DEG_180) begin
      a_sat = tao_pkg::DEG_180;
    end else if (data_i.a < tao_pkg::DEG_N180) begin
      a_sat = tao_pkg::DEG_N180;
    end else begin
      a_sat = data_i.a;
    end
    mag     = (a_sat < 0) ? tao_pkg::ANG_W'(-a_sat) : tao_pkg::ANG_W'(a_sat);
    mag_rnd = mag + tao_pkg::HALF_DEG;
    r_mag   = mag_rnd[tao_pkg::FRAC_BITS +: tao_pkg::MAG_W];
    res.neg = (a_sat < 0) && (r_mag != '0);
    r       = res.neg ? -tao_pkg::DEG_W'(r_mag) : tao_pkg::DEG_W'(r_mag);
    res.angle = r;
    res.mag   = mag[tao_pkg::FRAC_BITS +: tao_pkg::MAG_W];
    if (r <= tao_pkg::LIM_P45 && r > tao_pkg::LIM_N45) begin
      res.orient = tao_pkg::ORIENT_TOP;
    end else if (r <= tao_pkg::LIM_P135 && r > tao_pkg::LIM_P45) begin
      res.orient = tao_pkg::ORIENT_RIGHT;
    end else if (r <= tao_pkg::LIM_N45 && r > tao_pkg::LIM_N135) begin
      res.orient = tao_pkg::ORIENT_LEFT;
    end else begin
      res.orient = tao_pkg::ORIENT_BOTTOM;
    end
  end

endmodule

// ----- hdl/tilt_angle_orientation_top.sv -----
// tilt_angle_orientation_top: pipelined cordic atan2(x, y) tilt angle and orientation
// depends on tao_pkg, tao_prep, tao_cell, tao_post
//
// input channel: in_valid/in_ready carry one signed x/y accelerometer word
// output channel: out_valid/out_ready carry angle, truncated magnitude,
//   sign flag and orientation code for that word
// one result word for every input word, in order
// from input accept to out_valid a word passes the prep register, which loads
//   on the accept, then one register per cordic cell (16 rotation cells by
//   default) and then the output register
// throughput: one word per cycle unless stalled, set by the fully unrolled cell chain
// stall: while a result waits in the output register and out_ready is low,
//   the whole chain holds and in_ready is low; otherwise a new word is taken
//   in every cycle even while earlier words are in flight
// reset: rst_n low for one clock clears all valid bits; the chain is empty
//   and ready again in the first cycle after reset
module tilt_angle_orientation_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [8:0]  out_angle_deg,
  output logic [7:0]         out_magnitude_deg,
  output logic               out_negative_sign,
  output logic [1:0]         out_orientation
);

  logic                 adv;
  logic                 vld   [tao_pkg::NUM_CELLS+1];
  tao_pkg::tao_data_t   chain [tao_pkg::NUM_CELLS+1];
  tao_pkg::tao_result_t res;
  tao_pkg::tao_result_t res_r;
  logic                 out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  tao_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .accel_x  (in_accel_x),
    .accel_y  (in_accel_y),
    .vld_r    (vld[0]),
    .data_r   (chain[0])
  );

  for (genvar g = 0; g < tao_pkg::NUM_CELLS; g++) begin : g_cell
    tao_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .idx    (tao_pkg::IDX_W'(g)),
      .vld_i  (vld[g]),
      .data_i (chain[g]),
      .vld_r  (vld[g+1]),
      .data_r (chain[g+1])
    );
  end

  tao_post u_post (
    .data_i (chain[tao_pkg::NUM_CELLS]),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld[tao_pkg::NUM_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_angle_deg     = res_r.angle;
  assign out_magnitude_deg = res_r.mag;
  assign out_negative_sign = res_r.neg;
  assign out_orientation   = res_r.orient;

`ifndef SYNTH
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle_deg <= 10'sd180 && out_angle_deg >= -10'sd180))
    else $error("angle out of range");

  a_sign_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_negative_sign == out_angle_deg[8]))
    else $error("sign flag disagrees with angle");

  a_mag_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_negative_sign ? -out_angle_deg : out_angle_deg)
                   == $signed({1'b0, out_magnitude_deg})
                   || (out_negative_sign ? -out_angle_deg : out_angle_deg)
                   == $signed({1'b0, out_magnitude_deg}) + 9'sd1))
    else $error("magnitude does not match rounded angle");

  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> vld[tao_pkg::NUM_CELLS] == $past(vld[tao_pkg::NUM_CELLS]))
    else $error("cell chain moved during stall");
`endif

endmodule
